>>> sv/ctns_pkg.sv
// ============================================================================
// Cosmic tower neighbor select: shared package
// Payload types, register codes, controller states and the command/status
// bundles that join the controller to the datapath.
// ============================================================================
package ctns_pkg;

    // Field widths fixed by the interface.
    localparam int ETA_W    = 5;
    localparam int PHI_W    = 6;
    localparam int ENERGY_W = 20;
    localparam int CHI2_W   = 24;
    localparam int MASK_W   = 64;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Default grid geometry.
    localparam int ETA_ROWS_DEF    = 24;
    localparam int PHI_COLUMNS_DEF = 64;

    // Fit chi2 of 10000.0 in 1/16 units; towers above it are stored as zero.
    localparam logic [CHI2_W-1:0] CHI2_LIMIT = 24'd160000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOWER_THR = 2'd0,
        REG_VERT_THR  = 2'd1,
        REG_VETO_THR  = 2'd2
    } ctns_reg_t;

    // One input tower.
    typedef struct packed {
        logic [ETA_W-1:0]           tower_eta;
        logic [PHI_W-1:0]           tower_phi;
        logic signed [ENERGY_W-1:0] peak_energy;
        logic [CHI2_W-1:0]          fit_chi2;
        logic                       last_tower;
    } tower_t;

    // One row result.
    typedef struct packed {
        logic [ETA_W-1:0]  row_index;
        logic [MASK_W-1:0] pass_mask;
        logic              last_row;
        logic              event_good;
        logic [CNT_W-1:0]  event_total;
        logic [CNT_W-1:0]  good_event_total;
    } result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_COUNT,
        ST_EMIT_RD,
        ST_EMIT_LD
    } ctns_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic load_en;
        logic sweep_en;
        logic mask_rd_en;
        logic out_load;
        logic emit_next;
        logic count_en;
        logic event_end;
    } ctns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tower_accept;
        logic tower_last;
        logic scan_last;
        logic flush_done;
        logic out_free;
        logic emit_last;
    } ctns_status_t;

endpackage

>>> sv/cosmic_tower_neighbor_select_core.sv
// ============================================================================
// Cosmic tower neighbor select: top level
// Loads an event of calorimeter towers into a peak grid and, after the last
// tower, emits one pass mask per eta row with event counts.
// ============================================================================
// After reset the block runs a clearing pass over every cell of the peak grid
// with s_ready low. It then takes one tower per cycle. After the tower marked
// last, the grid is swept one cell per cycle through its single read port,
// followed by the read pipeline drain and the event counter update, and the
// row results follow one at a time, each loaded once the output register is
// free. New towers are taken again as soon as the final row result sits in
// the output register.
module cosmic_tower_neighbor_select_core
    import ctns_pkg::*;
#(
    parameter int ETA_ROWS    = ETA_ROWS_DEF,
    parameter int PHI_COLUMNS = PHI_COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ENERGY_W-1:0]  cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tower_t               s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_data
);

    ctns_cmd_t    ctrl_cmd;
    ctns_status_t dp_status;

    ctns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    ctns_datapath #(
        .ETA_ROWS    (ETA_ROWS),
        .PHI_COLUMNS (PHI_COLUMNS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Towers are taken only in the load phase.
    assign s_ready = ctrl_cmd.load_en;

endmodule

>>> sv/ctns_ctrl.sv
// ============================================================================
// Cosmic tower neighbor select: controller
// Sequences the grid clearing pass, tower loading, the row sweep, the event
// counter update and the row-by-row result emission.
// ============================================================================
module ctns_ctrl
    import ctns_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  ctns_status_t status,
    output ctns_cmd_t    cmd
);

    ctns_state_t state_reg;
    ctns_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.scan_last) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (status.tower_accept && status.tower_last) state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (status.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (status.flush_done) state_next = ST_COUNT;
            end
            ST_COUNT: begin
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clear_en   = 1'b1;
            ST_LOAD:    cmd.load_en    = 1'b1;
            ST_SWEEP:   cmd.sweep_en   = 1'b1;
            ST_DRAIN:   cmd            = '0;
            ST_COUNT:   cmd.count_en   = 1'b1;
            ST_EMIT_RD: cmd.mask_rd_en = 1'b1;
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.emit_next = !status.emit_last;
                    cmd.event_end = status.emit_last;
                end
            end
            default:    cmd = '0;
        endcase
    end

endmodule

>>> sv/ctns_row_eval.sv
// ============================================================================
// Cosmic tower neighbor select: row evaluation
// Forms the pass mask of one eta row from per-tower threshold flags of that
// row and the veto flags of the rows below and above it.
// ============================================================================
module ctns_row_eval
    import ctns_pkg::*;
#(
    parameter int PHI_COLUMNS = PHI_COLUMNS_DEF
) (
    input  logic [PHI_COLUMNS-1:0] cur_tower,
    input  logic [PHI_COLUMNS-1:0] cur_vert,
    input  logic [PHI_COLUMNS-1:0] prev_veto,
    input  logic                   use_prev,
    input  logic [PHI_COLUMNS-1:0] next_veto,
    input  logic                   use_next,
    output logic [PHI_COLUMNS-1:0] mask
);

    // Each column looks at its two phi neighbors, wrapping around the ring.
    for (genvar p = 0; p < PHI_COLUMNS; p++) begin : g_col
        localparam int UP = (p + 1) % PHI_COLUMNS;
        localparam int DN = (p + PHI_COLUMNS - 1) % PHI_COLUMNS;

        logic prev_hit;
        logic next_hit;

        assign prev_hit = use_prev && (prev_veto[DN] || prev_veto[p] || prev_veto[UP]);
        assign next_hit = use_next && (next_veto[DN] || next_veto[p] || next_veto[UP]);
        assign mask[p]  = cur_tower[p] && cur_vert[UP] && cur_vert[DN]
                          && !prev_hit && !next_hit;
    end

endmodule

>>> sv/ctns_datapath.sv
// ============================================================================
// Cosmic tower neighbor select: datapath
// Holds the peak grid memory, the threshold registers, the flag rows built
// during the sweep, the mask memory, the event counters and the output
// register.
// ============================================================================
module ctns_datapath
    import ctns_pkg::*;
#(
    parameter int ETA_ROWS    = ETA_ROWS_DEF,
    parameter int PHI_COLUMNS = PHI_COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctns_cmd_t            cmd,
    output ctns_status_t         status,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ENERGY_W-1:0]  cfg_data,
    input  logic                 s_valid,
    input  tower_t               s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_data
);

    localparam int GRID_DEPTH = ETA_ROWS * PHI_COLUMNS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int ROW_W      = $clog2(ETA_ROWS);
    localparam int COL_W      = $clog2(PHI_COLUMNS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ETA_ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(PHI_COLUMNS - 1);

    // Threshold registers.
    logic signed [ENERGY_W-1:0] tower_thr_reg;
    logic signed [ENERGY_W-1:0] vert_thr_reg;
    logic signed [ENERGY_W-1:0] veto_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tower_thr_reg <= '0;
            vert_thr_reg  <= '0;
            veto_thr_reg  <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TOWER_THR: tower_thr_reg <= cfg_data;
                REG_VERT_THR:  vert_thr_reg  <= cfg_data;
                REG_VETO_THR:  veto_thr_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Scan counters shared by the clearing pass and the sweep.
    logic [ROW_W-1:0] scan_row_reg;
    logic [COL_W-1:0] scan_col_reg;
    logic             scan_last;
    logic             scan_en;

    assign scan_en   = cmd.clear_en || cmd.sweep_en;
    assign scan_last = (scan_row_reg == LAST_ROW) && (scan_col_reg == LAST_COL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_row_reg <= '0;
            scan_col_reg <= '0;
        end else if (scan_en) begin
            if (scan_col_reg == LAST_COL) begin
                scan_col_reg <= '0;
                scan_row_reg <= scan_last ? '0 : scan_row_reg + ROW_W'(1);
            end else begin
                scan_col_reg <= scan_col_reg + COL_W'(1);
            end
        end
    end

    // Tower write address and range check.
    logic              tower_accept;
    logic              in_range;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] scan_addr;
    logic signed [ENERGY_W-1:0] load_value;

    assign tower_accept = s_valid && cmd.load_en;
    assign in_range     = ({2'b00, s_data.tower_eta} < 7'(ETA_ROWS))
                          && ({1'b0, s_data.tower_phi} < 7'(PHI_COLUMNS));
    assign load_addr    = ADDR_W'(s_data.tower_eta) * ADDR_W'(PHI_COLUMNS)
                          + ADDR_W'(s_data.tower_phi);
    assign scan_addr    = ADDR_W'(scan_row_reg) * ADDR_W'(PHI_COLUMNS)
                          + ADDR_W'(scan_col_reg);
    assign load_value   = (s_data.fit_chi2 > CHI2_LIMIT) ? '0 : s_data.peak_energy;

    // Peak grid memory: one write port, one registered read port.
    logic signed [ENERGY_W-1:0] grid_mem [GRID_DEPTH];
    logic signed [ENERGY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            grid_mem[scan_addr] <= '0;
        end else if (tower_accept && in_range) begin
            grid_mem[load_addr] <= load_value;
        end
        if (cmd.sweep_en) begin
            rd_data_reg <= grid_mem[scan_addr];
        end
    end

    // Read pipeline tags.
    logic             rd_valid_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic [COL_W-1:0] rd_col_reg;
    logic             row_done_reg;
    logic [ROW_W-1:0] done_row_reg;
    logic             flush_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            row_done_reg <= 1'b0;
            flush_reg    <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.sweep_en;
            row_done_reg <= rd_valid_reg && (rd_col_reg == LAST_COL);
            flush_reg    <= row_done_reg && (done_row_reg == LAST_ROW);
        end
    end

    always_ff @(posedge aclk) begin
        rd_row_reg   <= scan_row_reg;
        rd_col_reg   <= scan_col_reg;
        done_row_reg <= rd_row_reg;
    end

    // Flag rows: the row being read, the row under evaluation and the veto
    // flags of the row before it.
    logic [PHI_COLUMNS-1:0] fill_tower_reg;
    logic [PHI_COLUMNS-1:0] fill_vert_reg;
    logic [PHI_COLUMNS-1:0] fill_veto_reg;
    logic [PHI_COLUMNS-1:0] cur_tower_reg;
    logic [PHI_COLUMNS-1:0] cur_vert_reg;
    logic [PHI_COLUMNS-1:0] cur_veto_reg;
    logic [PHI_COLUMNS-1:0] prev_veto_reg;

    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            fill_tower_reg[rd_col_reg] <= (rd_data_reg >= tower_thr_reg);
            fill_vert_reg[rd_col_reg]  <= (rd_data_reg >= vert_thr_reg);
            fill_veto_reg[rd_col_reg]  <= (rd_data_reg > veto_thr_reg);
        end
        if (row_done_reg) begin
            cur_tower_reg <= fill_tower_reg;
            cur_vert_reg  <= fill_vert_reg;
            cur_veto_reg  <= fill_veto_reg;
            prev_veto_reg <= cur_veto_reg;
        end
    end

    // Mask of the row under evaluation. A completed row finishes the row
    // before it; the flush step finishes the top row, which has no row above.
    logic [PHI_COLUMNS-1:0] eval_mask;
    logic                   eval_use_prev;
    logic                   mask_we;
    logic [ROW_W-1:0]       mask_waddr;

    assign eval_use_prev = flush_reg || (done_row_reg >= ROW_W'(2));
    assign mask_we       = flush_reg || (row_done_reg && (done_row_reg != '0));
    assign mask_waddr    = flush_reg ? LAST_ROW : done_row_reg - ROW_W'(1);

    ctns_row_eval #(
        .PHI_COLUMNS (PHI_COLUMNS)
    ) u_row_eval (
        .cur_tower (cur_tower_reg),
        .cur_vert  (cur_vert_reg),
        .prev_veto (prev_veto_reg),
        .use_prev  (eval_use_prev),
        .next_veto (fill_veto_reg),
        .use_next  (!flush_reg),
        .mask      (eval_mask)
    );

    // Mask memory, one entry per eta row.
    logic [PHI_COLUMNS-1:0] mask_mem [ETA_ROWS];
    logic [PHI_COLUMNS-1:0] mask_rd_reg;
    logic [ROW_W-1:0]       emit_row_reg;

    always_ff @(posedge aclk) begin
        if (mask_we) begin
            mask_mem[mask_waddr] <= eval_mask;
        end
        if (cmd.mask_rd_en) begin
            mask_rd_reg <= mask_mem[emit_row_reg];
        end
    end

    // Event flag and counters.
    logic             any_pass_reg;
    logic [CNT_W-1:0] event_cnt_reg;
    logic [CNT_W-1:0] good_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            any_pass_reg  <= 1'b0;
            event_cnt_reg <= '0;
            good_cnt_reg  <= '0;
        end else begin
            if (cmd.event_end) begin
                any_pass_reg <= 1'b0;
            end else if (mask_we && (eval_mask != '0)) begin
                any_pass_reg <= 1'b1;
            end
            if (cmd.count_en) begin
                event_cnt_reg <= event_cnt_reg + CNT_W'(1);
                if (any_pass_reg) good_cnt_reg <= good_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Emission row counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_row_reg <= '0;
        end else if (cmd.event_end) begin
            emit_row_reg <= '0;
        end else if (cmd.emit_next) begin
            emit_row_reg <= emit_row_reg + ROW_W'(1);
        end
    end

    // Output register.
    logic    out_valid_reg;
    result_t out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg.row_index        <= ETA_W'(emit_row_reg);
            out_data_reg.pass_mask        <= MASK_W'(mask_rd_reg);
            out_data_reg.last_row         <= (emit_row_reg == LAST_ROW);
            out_data_reg.event_good       <= any_pass_reg;
            out_data_reg.event_total      <= event_cnt_reg;
            out_data_reg.good_event_total <= good_cnt_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Status to the controller.
    assign status.tower_accept = tower_accept;
    assign status.tower_last   = s_data.last_tower;
    assign status.scan_last    = scan_last;
    assign status.flush_done   = flush_reg;
    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.emit_last    = (emit_row_reg == LAST_ROW);

endmodule

>>> sv/ctns_checker.sv
// ============================================================================
// Cosmic tower neighbor select: port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module ctns_checker
    import ctns_pkg::*;
#(
    parameter int PHI_COLUMNS = PHI_COLUMNS_DEF
) (
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input tower_t  s_data,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    localparam logic [MASK_W-1:0] UNUSED_BITS = (PHI_COLUMNS >= MASK_W) ? '0 :
                                                ~((MASK_W'(1) << PHI_COLUMNS) - MASK_W'(1));

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // The final row of an event is followed by a gap while the next event loads.
    a_gap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_row |=> !m_valid)
        else $error("result beat right after the final row");

    // The tower closing an event stops loading until the event's row results are emitted.
    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_tower |=> !s_ready)
        else $error("tower taken right after the last tower");

    // A nonempty mask means the event is good.
    a_good_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.event_good |-> m_data.pass_mask == '0)
        else $error("pass mask set in an event marked not good");

    // Columns beyond the ring never pass.
    a_unused_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pass_mask & UNUSED_BITS) == '0)
        else $error("pass mask bit set beyond the last phi column");

endmodule

bind cosmic_tower_neighbor_select_core ctns_checker #(
    .PHI_COLUMNS (PHI_COLUMNS)
) u_ctns_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
